// File: rtl/rmsp_pkg.sv
package rmsp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_STEP_SIZE   = 2'd0;
  localparam logic [1:0] CFG_DECAY_ALPHA = 2'd1;
  localparam logic [1:0] CFG_EPSILON     = 2'd2;
  localparam logic [1:0] CFG_MOMENTUM    = 2'd3;

  localparam int unsigned CFG_DATA_W = 48;
  localparam logic [16:0] ALPHA_ONE  = 17'd65536;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // Input beat.
  typedef struct packed {
    logic [11:0]        element_index;
    logic signed [31:0] weight_value;
    logic signed [31:0] grad_value;
  } rmsp_in_t;

  // Result beat.
  typedef struct packed {
    logic [11:0]        element_index_out;
    logic signed [31:0] weight_new;
    logic               numeric_flag;
  } rmsp_out_t;

  // Register file contents as seen by the datapath; alpha already clamped.
  typedef struct packed {
    logic [31:0] step_size;
    logic [16:0] alpha;
    logic [47:0] epsilon;
    logic [15:0] momentum;
  } rmsp_cfg_t;

  // Classified item queued between the front and the back.
  typedef struct packed {
    logic [11:0]        idx;
    logic signed [31:0] w;
    logic               gneg;
    logic [31:0]        gmag;
    logic [63:0]        g2;
  } rmsp_item_t;

  // Per-item context carried down the back pipeline.
  typedef struct packed {
    logic [11:0]        idx;
    logic signed [31:0] w;
    logic               gneg;
    logic [31:0]        gmag;
    logic               bneg;
    logic [31:0]        pm;
    logic [63:0]        v;
    logic signed [31:0] x;
    logic               upd_b;
    logic               flag;
  } rmsp_ctx_t;

endpackage

// File: rtl/rmsp_front.sv
module rmsp_front #(
  parameter int unsigned ELEMENTS = 4096,
  parameter int unsigned SW       = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rmsp_pkg::rmsp_in_t   in_data_i,
  input  logic                 hold_i,
  input  logic                 pop_i,
  output logic                 head_valid_o,
  output rmsp_pkg::rmsp_item_t head_o,
  output logic [SW-1:0]        head_slot_o
);
  import rmsp_pkg::*;

  localparam int unsigned QD = 4;

  logic              accept;
  logic              a_vld_q;
  logic [11:0]       a_idx_q;
  logic signed [31:0] a_w_q;
  logic              a_gneg_q;
  logic [31:0]       a_gmag_q;
  logic [12:0]       a_quo_q;
  logic [12:0]       quo_d;
  logic              b_vld_q;
  rmsp_item_t        b_item_q;
  logic [SW-1:0]     b_slot_q;
  logic [SW-1:0]     slot_d;
  rmsp_item_t        fifo_q [QD];
  logic [SW-1:0]     fslot_q [QD];
  logic [1:0]        wr_ptr_q;
  logic [1:0]        rd_ptr_q;
  logic [2:0]        cnt_q;
  logic [3:0]        occ;

  // Items in the queue plus the two classify stages count against its depth.
  assign occ        = {1'b0, cnt_q} + {3'b0, a_vld_q} + {3'b0, b_vld_q};
  assign in_stall_o = hold_i || (occ >= 4'(QD));
  assign accept     = in_valid_i && !in_stall_o;

  // Element slot: index modulo the store depth, by reciprocal multiplication.
  if (ELEMENTS > 4096) begin : g_wide
    assign quo_d  = '0;
    assign slot_d = SW'(a_idx_q) | SW'(a_quo_q & 13'd0);
  end else begin : g_mod
    localparam logic [24:0] RECIP = 25'((2**24 + ELEMENTS - 1) / ELEMENTS);
    logic [36:0] qprod;
    logic [25:0] rem;
    assign qprod  = 37'(in_data_i.element_index) * 37'(RECIP);
    assign quo_d  = qprod[36:24];
    assign rem    = 26'(a_idx_q) - (26'(a_quo_q) * 26'(ELEMENTS));
    assign slot_d = rem[SW-1:0];
  end

  // Stage A: take the beat, split the gradient into sign and magnitude.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_idx_q  <= in_data_i.element_index;
      a_w_q    <= in_data_i.weight_value;
      a_gneg_q <= in_data_i.grad_value[31];
      a_gmag_q <= in_data_i.grad_value[31] ? 32'(-in_data_i.grad_value)
                                           : in_data_i.grad_value;
      a_quo_q  <= quo_d;
    end
  end

  // Stage B: squared gradient and final slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_vld_q) begin
      b_item_q.idx  <= a_idx_q;
      b_item_q.w    <= a_w_q;
      b_item_q.gneg <= a_gneg_q;
      b_item_q.gmag <= a_gmag_q;
      b_item_q.g2   <= 64'(a_gmag_q) * 64'(a_gmag_q);
      b_slot_q      <= slot_d;
    end
  end

  // Queue toward the back.
  always_ff @(posedge clk_i) begin
    if (b_vld_q) begin
      fifo_q[wr_ptr_q]  <= b_item_q;
      fslot_q[wr_ptr_q] <= b_slot_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (b_vld_q) wr_ptr_q <= wr_ptr_q + 2'd1;
      if (pop_i)   rd_ptr_q <= rd_ptr_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, b_vld_q} - {2'b0, pop_i};
    end
  end

  assign head_valid_o = (cnt_q != 3'd0);
  assign head_o       = fifo_q[rd_ptr_q];
  assign head_slot_o  = fslot_q[rd_ptr_q];

endmodule

// File: rtl/rmsp_back.sv
module rmsp_back #(
  parameter int unsigned ELEMENTS = 4096,
  parameter int unsigned SW       = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmsp_pkg::rmsp_cfg_t  cfg_i,
  input  logic                 head_valid_i,
  input  rmsp_pkg::rmsp_item_t head_i,
  input  logic [SW-1:0]        head_slot_i,
  output logic                 pop_o,
  output logic                 clearing_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rmsp_pkg::rmsp_out_t  out_data_o
);
  import rmsp_pkg::*;

  localparam int unsigned NSQ  = 32;
  localparam int unsigned SQ0  = 3;
  localparam int unsigned SD   = SQ0 + NSQ;
  localparam int unsigned NDV  = 32;
  localparam int unsigned DV0  = SD + 1;
  localparam int unsigned ST_S = DV0 + NDV;
  localparam int unsigned ST_L = ST_S + 1;
  localparam int unsigned NST  = ST_L + 1;

  // State stores.
  logic [63:0]        sa_mem [ELEMENTS];
  logic [31:0]        mb_mem [ELEMENTS];
  logic [63:0]        sa_rd_q;
  logic [31:0]        mb_rd_q;
  logic               sa_we;
  logic               mb_we;
  logic [SW-1:0]      wa;
  logic [63:0]        sa_wd;
  logic [31:0]        mb_wd;

  logic               clr_q;
  logic [SW-1:0]      clr_cnt_q;

  logic               adv;
  logic               hit;
  logic [NST-1:0]     vld_q;
  rmsp_ctx_t          ctx_q  [NST];
  rmsp_ctx_t          ctx_nx [NST];
  logic [SW-1:0]      slot_q [NST];
  logic [63:0]        g2_q;

  logic [48:0]        p_ah_q, p_al_q, p_bh_q, p_bl_q;
  logic [16:0]        beta;

  logic [33:0]        sq_rem_q  [NSQ];
  logic [31:0]        sq_root_q [NSQ];
  logic [63:0]        sq_rad_q  [NSQ];

  logic [48:0]        d_q;
  logic               dz_q;
  logic               ovf_q;
  logic [48:0]        d_calc;

  logic [48:0]        dv_rem_q [NDV];
  logic [31:0]        dv_quo_q [NDV];
  logic [48:0]        dv_d_q   [NDV];
  logic               dv_dz_q  [NDV];
  logic               dv_ovf_q [NDV];

  logic [63:0]        lp_q;
  logic               out_vld_q;
  rmsp_out_t          out_q;
  rmsp_out_t          out_d;

  assign adv         = !out_vld_q || !out_stall_i;
  assign clearing_o  = clr_q;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;
  assign beta        = ALPHA_ONE - cfg_i.alpha;

  // An element already in flight holds the head until it has been written back.
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NST; k++) begin
      if (vld_q[k] && (slot_q[k] == head_slot_i)) hit = 1'b1;
    end
  end

  assign pop_o = head_valid_i && !clr_q && adv && !hit;

  // Clearing pass after reset, one entry per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      clr_cnt_q <= clr_cnt_q + SW'(1);
      if (clr_cnt_q == SW'(ELEMENTS - 1)) clr_q <= 1'b0;
    end
  end

  // Write port: clearing, or write-back as an item leaves the last stage.
  always_comb begin
    if (clr_q) begin
      wa    = clr_cnt_q;
      sa_we = 1'b1;
      mb_we = 1'b1;
      sa_wd = '0;
      mb_wd = '0;
    end else begin
      wa    = slot_q[ST_L];
      sa_we = adv && vld_q[ST_L];
      mb_we = adv && vld_q[ST_L] && ctx_q[ST_L].upd_b;
      sa_wd = ctx_q[ST_L].v;
      mb_wd = ctx_q[ST_L].x;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sa_we) sa_mem[wa] <= sa_wd;
    if (mb_we) mb_mem[wa] <= mb_wd;
    if (pop_o) begin
      sa_rd_q <= sa_mem[head_slot_i];
      mb_rd_q <= mb_mem[head_slot_i];
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[NST-2:0], pop_o};
      out_vld_q <= vld_q[ST_L];
    end
  end

  // Context updates at the stages that produce new fields.
  always_comb begin
    logic [31:0]        babs;
    logic [47:0]        bprod;
    logic [49:0]        hi;
    logic [49:0]        lo;
    logic [31:0]        q;
    logic signed [31:0] s;
    logic               f;
    logic signed [32:0] dec;
    logic signed [33:0] sum;

    ctx_nx[0] = ctx_q[0];
    for (int k = 1; k < NST; k++) ctx_nx[k] = ctx_q[k-1];

    // Decayed momentum magnitude.
    babs  = mb_rd_q[31] ? 32'(-mb_rd_q) : mb_rd_q;
    bprod = 48'(babs) * 48'(cfg_i.momentum);
    ctx_nx[1].bneg = mb_rd_q[31];
    ctx_nx[1].pm   = bprod[47:16];

    // New squared average.
    hi = {1'b0, p_ah_q} + {1'b0, p_bh_q};
    lo = {1'b0, p_al_q} + {1'b0, p_bl_q};
    ctx_nx[2].v = {hi[47:0], 16'b0} + {14'b0, lo[49:16]};

    // Scaled gradient, then momentum accumulation.
    q = dv_quo_q[NDV-1];
    f = 1'b0;
    if (dv_dz_q[NDV-1]) begin
      s = '0;
      f = 1'b1;
    end else if (dv_ovf_q[NDV-1]) begin
      s = ctx_q[ST_S-1].gneg ? S32_MIN : S32_MAX;
      f = 1'b1;
    end else if (ctx_q[ST_S-1].gneg) begin
      if (q > 32'h8000_0000) begin
        s = S32_MIN;
        f = 1'b1;
      end else begin
        s = 32'(-q);
      end
    end else begin
      if (q > 32'h7fff_ffff) begin
        s = S32_MAX;
        f = 1'b1;
      end else begin
        s = q;
      end
    end
    dec = ctx_q[ST_S-1].bneg ? -$signed({1'b0, ctx_q[ST_S-1].pm})
                             : $signed({1'b0, ctx_q[ST_S-1].pm});
    sum = 34'(dec) + 34'(s);
    ctx_nx[ST_S].upd_b = (cfg_i.momentum != 16'd0);
    if (cfg_i.momentum != 16'd0) begin
      if (sum > 34'sd2147483647) begin
        ctx_nx[ST_S].x = S32_MAX;
        f = 1'b1;
      end else if (sum < -34'sd2147483648) begin
        ctx_nx[ST_S].x = S32_MIN;
        f = 1'b1;
      end else begin
        ctx_nx[ST_S].x = sum[31:0];
      end
    end else begin
      ctx_nx[ST_S].x = s;
    end
    ctx_nx[ST_S].flag = f;
  end

  // Payload of the stages.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_q[0].idx   <= head_i.idx;
      ctx_q[0].w     <= head_i.w;
      ctx_q[0].gneg  <= head_i.gneg;
      ctx_q[0].gmag  <= head_i.gmag;
      ctx_q[0].bneg  <= 1'b0;
      ctx_q[0].pm    <= '0;
      ctx_q[0].v     <= '0;
      ctx_q[0].x     <= '0;
      ctx_q[0].upd_b <= 1'b0;
      ctx_q[0].flag  <= 1'b0;
      slot_q[0]      <= head_slot_i;
      g2_q           <= head_i.g2;
      for (int k = 1; k < NST; k++) begin
        ctx_q[k]  <= ctx_nx[k];
        slot_q[k] <= slot_q[k-1];
      end
      // Blend partial products.
      p_ah_q <= 49'(cfg_i.alpha) * 49'(sa_rd_q[63:32]);
      p_al_q <= 49'(cfg_i.alpha) * 49'(sa_rd_q[31:0]);
      p_bh_q <= 49'(beta) * 49'(g2_q[63:32]);
      p_bl_q <= 49'(beta) * 49'(g2_q[31:0]);
      // Denominator from the root.
      d_q   <= d_calc;
      dz_q  <= (d_calc == 49'd0);
      ovf_q <= ({17'b0, ctx_q[SD-1].gmag} >= d_calc);
      // Step-size product on the unsigned magnitude of the step.
      lp_q  <= {32'b0, (ctx_q[ST_S].x[31] ? 32'(-ctx_q[ST_S].x) : ctx_q[ST_S].x)}
             * {32'b0, cfg_i.step_size};
      out_q <= out_d;
    end
  end

  assign d_calc = {1'b0, sq_root_q[NSQ-1], 16'b0} + {1'b0, cfg_i.epsilon};

  // Square root, one result bit per stage.
  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    logic [33:0] rem_in;
    logic [31:0] root_in;
    logic [63:0] rad_in;
    logic [33:0] r2;
    logic [33:0] t;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = ctx_q[SQ0-1].v;
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
    end
    assign r2 = {rem_in[31:0], rad_in[63:62]};
    assign t  = {root_in, 2'b01};
    assign ge = (r2 >= t);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rem_q[k]  <= ge ? (r2 - t) : r2;
        sq_root_q[k] <= {root_in[30:0], ge};
        sq_rad_q[k]  <= {rad_in[61:0], 2'b00};
      end
    end
  end

  // Restoring division of |g|*2^32 by the denominator, one quotient bit per stage.
  for (genvar k = 0; k < NDV; k++) begin : g_div
    logic [48:0] rem_in;
    logic [31:0] quo_in;
    logic [48:0] d_in;
    logic        dz_in;
    logic        ovf_in;
    logic [49:0] r2;
    logic [49:0] diff;
    logic        ge;
    if (k == 0) begin : g_first
      assign rem_in = ovf_q ? 49'd0 : {17'b0, ctx_q[SD].gmag};
      assign quo_in = '0;
      assign d_in   = d_q;
      assign dz_in  = dz_q;
      assign ovf_in = ovf_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[k-1];
      assign quo_in = dv_quo_q[k-1];
      assign d_in   = dv_d_q[k-1];
      assign dz_in  = dv_dz_q[k-1];
      assign ovf_in = dv_ovf_q[k-1];
    end
    assign r2   = {rem_in, 1'b0};
    assign diff = r2 - {1'b0, d_in};
    assign ge   = (r2 >= {1'b0, d_in});
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rem_q[k] <= ge ? diff[48:0] : r2[48:0];
        dv_quo_q[k] <= {quo_in[30:0], ge};
        dv_d_q[k]   <= d_in;
        dv_dz_q[k]  <= dz_in;
        dv_ovf_q[k] <= ovf_in;
      end
    end
  end

  // Weight update and final saturation.
  always_comb begin
    logic [39:0]        xmag;
    logic signed [40:0] u;
    logic signed [41:0] wn;
    xmag = lp_q[63:24];
    u    = ctx_q[ST_L].x[31] ? -$signed({1'b0, xmag}) : $signed({1'b0, xmag});
    wn   = 42'(ctx_q[ST_L].w) - 42'(u);
    out_d.element_index_out = ctx_q[ST_L].idx;
    out_d.numeric_flag      = ctx_q[ST_L].flag;
    if (wn > 42'sd2147483647) begin
      out_d.weight_new   = S32_MAX;
      out_d.numeric_flag = 1'b1;
    end else if (wn < -42'sd2147483648) begin
      out_d.weight_new   = S32_MIN;
      out_d.numeric_flag = 1'b1;
    end else begin
      out_d.weight_new = wn[31:0];
    end
  end

endmodule

// File: rtl/rmsprop_update.sv
// Element-wise RMSprop weight update with optional momentum, fixed point.
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per element,
// carrying its index, weight and gradient. Output channel (out_valid_o /
// out_stall_i / out_data_o): one result beat per input beat, in input order.
// Configuration channel (cfg_valid_i / cfg_ready_o): always ready; writes
// take effect on the next cycle and belong only to idle periods.
// Throughput is one beat per cycle while no beat addresses an element still
// in flight and the receiver does not stall. A beat whose element is in
// flight waits at the head of the queue until the earlier one is written back.
// From the accepting edge to the result, a beat passes two classify stages,
// the queue, the state read, the blend in two stages, 32 square-root stages,
// the denominator stage, 32 divider stages, momentum, the step-size product
// and the output register. After reset both state stores are cleared in a
// pass over every entry, during which in_stall_o stays high. When the receiver
// stalls, the output beat holds and the whole back pipeline freezes; the front
// queue keeps taking beats until its four places are spoken for.
module rmsprop_update #(
  parameter int unsigned ELEMENTS = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rmsp_pkg::rmsp_in_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rmsp_pkg::rmsp_out_t   out_data_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [47:0]           cfg_data_i
);
  import rmsp_pkg::*;

  localparam int unsigned SW = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;

  logic [31:0]   lr_q;
  logic [16:0]   alpha_q;
  logic [47:0]   eps_q;
  logic [15:0]   mom_q;
  rmsp_cfg_t     cfg;
  logic          head_valid;
  rmsp_item_t    head;
  logic [SW-1:0] head_slot;
  logic          pop;
  logic          clearing;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q    <= 32'd167772;
      alpha_q <= 17'd64881;
      eps_q   <= 48'd43;
      mom_q   <= 16'd0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_STEP_SIZE:   lr_q    <= cfg_data_i[31:0];
        CFG_DECAY_ALPHA: alpha_q <= cfg_data_i[16:0];
        CFG_EPSILON:     eps_q   <= cfg_data_i;
        CFG_MOMENTUM:    mom_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Alpha above one acts as one.
  assign cfg.step_size = lr_q;
  assign cfg.alpha     = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
  assign cfg.epsilon   = eps_q;
  assign cfg.momentum  = mom_q;

  rmsp_front #(
    .ELEMENTS (ELEMENTS),
    .SW       (SW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .hold_i       (clearing),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head),
    .head_slot_o  (head_slot)
  );

  rmsp_back #(
    .ELEMENTS (ELEMENTS),
    .SW       (SW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .head_valid_i (head_valid),
    .head_i       (head),
    .head_slot_i  (head_slot),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

  // No beat is taken while the stores are being cleared.
  a_clear_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> in_stall_o)
    else $error("input accepted during clearing pass");

  // The back never starts an item during the clearing pass.
  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (!clearing && head_valid))
    else $error("item issued while clearing or queue empty");

  // No result can exist while clearing, since the pipeline is empty then.
  a_no_out_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o)
    else $error("result present during clearing pass");

endmodule
